>>> design/assert_macros.svh
// assertion macros for the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("check failed");
// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("check failed");
`endif

>>> design/sha256_pkg.sv
// constants, types and round functions for the sha-256 hasher
`default_nettype none
package sha256_pkg;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrW = 2;

	// one entry from front to back: a word for the block buffer
	typedef struct packed {
		logic [31:0] word;
		logic        finish;   // last word of the padded message (low length word): emit digest after its block
	} sha_cmd_t;

	localparam logic [31:0] InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sig_lo(input logic [31:0] x);
		sig_lo = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig_hi(input logic [31:0] x);
		sig_hi = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction
endpackage
`default_nettype wire

>>> design/sha256_front.sv
// front end: counts bytes, pads the last word and expands it into buffer words
`default_nettype none
module sha256_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  valid,
	output logic                       stall,
	input  wire logic [31:0]           message_word,
	input  wire logic [2:0]            byte_count,
	input  wire logic                  is_last,
	output logic                       cmd_valid,
	input  wire logic                  cmd_stall,
	output sha256_pkg::sha_cmd_t       cmd
);
	import sha256_pkg::*;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StPad  = 2'd1;
	localparam logic [1:0] StHi   = 2'd2;
	localparam logic [1:0] StLo   = 2'd3;

	logic [1:0]  state_q;
	logic [3:0]  pos_q;
	logic [60:0] bytes_q;
	logic        pad80_q;    // the 0x80 word is still owed (full last word)
	logic [2:0]  cnt;
	logic [60:0] bytes_new;
	logic [31:0] keep;
	logic [31:0] padded;
	logic [63:0] bits;
	logic        take;
	logic        fire;

	assign cnt = (byte_count > 3'd4) ? 3'd4 : byte_count;
	assign bytes_new = bytes_q + (is_last ? {58'd0, cnt} : 61'd4);
	assign bits = {bytes_q, 3'b000};
	assign fire = cmd_valid && !cmd_stall;
	assign stall = (state_q != StIdle) || cmd_stall;
	assign take = valid && !stall;

	always_comb begin
		case (cnt)
			3'd0: keep = 32'h0000_0000;
			3'd1: keep = 32'hff00_0000;
			3'd2: keep = 32'hffff_0000;
			3'd3: keep = 32'hffff_ff00;
			default: keep = 32'hffff_ffff;
		endcase
		case (cnt)
			3'd0: padded = 32'h8000_0000;
			3'd1: padded = (message_word & keep) | 32'h0080_0000;
			3'd2: padded = (message_word & keep) | 32'h0000_8000;
			3'd3: padded = (message_word & keep) | 32'h0000_0080;
			default: padded = message_word;
		endcase
	end

	always_comb begin
		cmd_valid = 1'b0;
		cmd = '{word: 32'd0, finish: 1'b0};
		case (state_q)
			StIdle: begin
				cmd_valid = valid;
				cmd.word = (is_last && cnt != 3'd4) ? padded : message_word;
			end
			StPad: begin
				cmd_valid = 1'b1;
				cmd.word = pad80_q ? 32'h8000_0000 : 32'd0;
			end
			StHi: begin
				cmd_valid = 1'b1;
				cmd.word = bits[63:32];
			end
			default: begin
				cmd_valid = 1'b1;
				cmd.word = bits[31:0];
				cmd.finish = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			pos_q <= 4'd0;
			bytes_q <= 61'd0;
			pad80_q <= 1'b0;
		end else if (state_q == StIdle) begin
			if (take) begin
				pos_q <= pos_q + 4'd1;
				bytes_q <= bytes_new;
				if (is_last) begin
					pad80_q <= (cnt == 3'd4);
					// padded word in slot 13 goes straight to the length words
					state_q <= (cnt != 3'd4 && pos_q == 4'd13) ? StHi : StPad;
				end
			end
		end else if (fire) begin
			pos_q <= pos_q + 4'd1;
			case (state_q)
				StPad: begin
					pad80_q <= 1'b0;
					if (pos_q == 4'd13) state_q <= StHi;
				end
				StHi: state_q <= StLo;
				default: begin
					state_q <= StIdle;
					pos_q <= 4'd0;
					bytes_q <= 61'd0;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

>>> design/sha256_queue.sv
// small fifo between front end and compression core
`default_nettype none
module sha256_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_valid,
	output logic                       wr_stall,
	input  wire sha256_pkg::sha_cmd_t  wr_data,
	output logic                       rd_valid,
	input  wire logic                  rd_stall,
	output sha256_pkg::sha_cmd_t       rd_data
);
	import sha256_pkg::*;

	sha_cmd_t             mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wp_q;
	logic [QueuePtrW-1:0] rp_q;
	logic [QueuePtrW:0]   cnt_q;
	logic                 wr;
	logic                 rd;

	assign wr_stall = (cnt_q == (QueuePtrW+1)'(QueueDepth));
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && !wr_stall;
	assign rd = rd_valid && !rd_stall;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QueuePtrW+1)'(wr) - (QueuePtrW+1)'(rd);
		end
	end
endmodule
`default_nettype wire

>>> design/sha256_core.sv
// back end: block buffer, 64-round compression and digest output
`default_nettype none
module sha256_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_stall,
	input  wire sha256_pkg::sha_cmd_t  cmd,
	output logic                       valid,
	input  wire logic                  stall,
	output logic [31:0]                digest_word,
	output logic [2:0]                 word_index,
	output logic                       last_word
);
	import sha256_pkg::*;

	localparam logic [1:0] StLoad = 2'd0;
	localparam logic [1:0] StRound = 2'd1;
	localparam logic [1:0] StAdd = 2'd2;
	localparam logic [1:0] StOut = 2'd3;

	logic [1:0]  state_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [3:0]  pos_q;
	logic [5:0]  rnd_q;
	logic        fin_q;
	logic [2:0]  oidx_q;
	logic [31:0] w_new;
	logic [31:0] s1, s0, ch, mj, t1;
	logic        take;

	assign cmd_stall = (state_q != StLoad);
	assign take = cmd_valid && !cmd_stall;
	assign w_new = w_q[0] + sig_lo(w_q[1]) + w_q[9] + sig_hi(w_q[14]);
	assign s1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign t1 = v_q[7] + s1 + ch + RoundK[rnd_q] + w_q[0];
	assign s0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
	assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);

	assign valid = (state_q == StOut);
	assign digest_word = h_q[oidx_q];
	assign word_index = oidx_q;
	assign last_word = (oidx_q == 3'd7);

	// schedule words shift through w_q; w_q[0] is the current round's word
	always_ff @(posedge clk) begin
		if (take) w_q[pos_q] <= cmd.word;
		if (state_q == StRound) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + s0 + mj;
		end
		if (take && pos_q == 4'd15) v_q <= h_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StLoad;
			pos_q <= 4'd0;
			rnd_q <= 6'd0;
			fin_q <= 1'b0;
			oidx_q <= 3'd0;
			h_q <= InitH;
		end else begin
			case (state_q)
				StLoad: if (take) begin
					pos_q <= pos_q + 4'd1;
					if (pos_q == 4'd15) begin
						fin_q <= cmd.finish;
						rnd_q <= 6'd0;
						state_q <= StRound;
					end
				end
				StRound: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= StAdd;
				end
				StAdd: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					oidx_q <= 3'd0;
					state_q <= fin_q ? StOut : StLoad;
				end
				default: if (!stall) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						h_q <= InitH;
						state_q <= StLoad;
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire

>>> design/sha256_stream_hasher_top.sv
// top level of the streaming sha-256 hasher
// per block the core loads 16 buffer words, runs 64 rounds and one add step; it takes no new
// word while it runs the rounds, the add or the digest output
// the compression core (one round per cycle) sets the rate; the front pads the last word
// digest words leave one per cycle unless stalled, eight per message
// arst_n clears all control state and loads the initial hash values; no clearing pass
`default_nettype none
module sha256_stream_hasher_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] message_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	import sha256_pkg::*;

	// front to queue transfer
	logic     f_valid;
	logic     f_stall;
	sha_cmd_t f_cmd;
	// queue to core transfer
	logic     c_valid;
	logic     c_stall;
	sha_cmd_t c_cmd;

	// front expands each message word and the padding into buffer words
	sha256_front u_front (
		.clk, .arst_n,
		.valid(in_valid), .stall(in_stall),
		.message_word, .byte_count, .is_last,
		.cmd_valid(f_valid), .cmd_stall(f_stall), .cmd(f_cmd)
	);

	// decouples the front from the compression rounds
	sha256_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_cmd),
		.rd_valid(c_valid), .rd_stall(c_stall), .rd_data(c_cmd)
	);

	// compression and digest output
	sha256_core u_core (
		.clk, .arst_n,
		.cmd_valid(c_valid), .cmd_stall(c_stall), .cmd(c_cmd),
		.valid(out_valid), .stall(out_stall),
		.digest_word, .word_index, .last_word
	);
endmodule
`default_nettype wire

>>> design/sha256_checker.sv
// port-level checks for the sha-256 hasher, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module sha256_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] digest_word,
	input wire logic [2:0]  word_index,
	input wire logic        last_word
);
	logic adv;

	// a digest word other than the last one moves on
	assign adv = out_valid && !out_stall && !last_word;

	`CHK_IMPLY(a_last_idx, clk, arst_n, out_valid, (last_word == (word_index == 3'd7)))
	`CHK_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(digest_word))
	`CHK_NEXT(a_next_idx, clk, arst_n, adv, out_valid && word_index == $past(word_index) + 3'd1)
endmodule
bind sha256_stream_hasher_top sha256_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .digest_word, .word_index, .last_word
);
`default_nettype wire
